[rtl/cpf_pkg.sv]
// Shared constants, types and codes of the column profile feature block.
`default_nettype none
package cpf_pkg;
    localparam int COLUMN_HEIGHT = 64;
    localparam int ROW_W  = 6;
    localparam int N_W    = 7;
    localparam int SUM_W  = 14;
    localparam int M1_W   = 20;
    localparam int M2_W   = 26;
    localparam int SQ_W   = 12;
    localparam int NUM_W  = 36;
    localparam int DEN_W  = 14;
    localparam int CNT_W  = 6;
    localparam int OUT_W  = 104;

    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_GRAVITY = 2'd1,
        OP_MOMENT  = 2'd2,
        OP_FILL    = 2'd3
    } t_op;

    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic store_q;
        logic load_out;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic col_done;
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

[rtl/column_profile_features.sv]
// Top level of the column profile feature extractor.
`default_nettype none
// Pixels of a text-line image enter one per transfer, top to bottom down each
// column, with tlast on the last pixel; a column also ends by itself after 64
// pixels. Pixels are accepted while a column is collected. When a column ends
// the block stops taking pixels while one shared restoring divider, giving one
// quotient bit a cycle, works out the mean, the two moments and the fill ratio
// in four divisions in turn. The result then moves into the output register
// once that register is free, and the next column may start, even while that
// result still waits to be taken. The threshold is written through its own
// channel, which is always ready, and should be changed only between columns.
module column_profile_features
    import cpf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [7:0]       i_cfg_data,   // threshold
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata, // pixel
    input  wire logic             s_axis_tlast, // column_end
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // From bit 0: weight 16, gravity 22, moment_two 22, upper_contour 6,
    // lower_contour 6, upper_gradient 9, lower_gradient 9, transitions 6,
    // fill_ratio 8.
    output logic [OUT_W-1:0]      m_axis_tdata
);
    t_cmd             cmd;
    t_sts             sts;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = cmd.in_ready;

    cpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .o_m_tvalid (m_axis_tvalid)
    );

    cpf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_pixel      (s_axis_tdata),
        .i_column_end (s_axis_tlast),
        .o_div_start  (div_start),
        .o_div_num    (div_num),
        .o_div_den    (div_den),
        .i_div_done   (div_done),
        .i_div_quo    (div_quo),
        .o_result     (m_axis_tdata)
    );

    cpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );
endmodule
`default_nettype wire

[rtl/cpf_div.sv]
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module cpf_div
    import cpf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo
);
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   diff;

    always_comb begin
        rem_sh = {r_rem, r_q[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        diff   = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

[rtl/cpf_ctrl.sv]
// Controller sequencing pixel collection, the four divisions and the result hand-off.
`default_nettype none
module cpf_ctrl
    import cpf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    input  wire logic i_m_tready,
    output t_cmd      o_cmd,
    output logic      o_m_tvalid
);
    typedef enum logic [1:0] {S_COLLECT, S_START, S_BUSY, S_OUT} t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_out_valid;
    logic   load;

    assign load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        o_cmd.in_ready  = (r_state == S_COLLECT);
        o_cmd.div_start = (r_state == S_START);
        o_cmd.store_q   = (r_state == S_BUSY) && i_sts.div_done;
        o_cmd.load_out  = load;
        o_cmd.op        = r_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_op        <= OP_WEIGHT;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_COLLECT: begin
                    if (i_sts.col_done) begin
                        r_op    <= OP_WEIGHT;
                        r_state <= S_START;
                    end
                end
                S_START: r_state <= S_BUSY;
                S_BUSY: begin
                    if (i_sts.div_done) begin
                        if (r_op == OP_FILL) begin
                            r_state <= S_OUT;
                        end else begin
                            r_op    <= t_op'(r_op + 2'd1);
                            r_state <= S_START;
                        end
                    end
                end
                S_OUT: begin
                    if (load) r_state <= S_COLLECT;
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
endmodule
`default_nettype wire

[rtl/cpf_dp.sv]
// Datapath: per-pixel accumulation, column snapshot, divider operands and result register.
`default_nettype none
module cpf_dp
    import cpf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic             i_cfg_valid,
    input  wire logic [7:0]       i_cfg_data,
    input  wire logic             i_s_tvalid,
    input  wire logic [7:0]       i_pixel,
    input  wire logic             i_column_end,
    output logic                  o_div_start,
    output logic [NUM_W-1:0]      o_div_num,
    output logic [DEN_W-1:0]      o_div_den,
    input  wire logic             i_div_done,
    input  wire logic [NUM_W-1:0] i_div_quo,
    output logic [OUT_W-1:0]      o_result
);
    logic [7:0]       r_thr;
    logic [ROW_W-1:0] r_row;
    logic [SQ_W-1:0]  r_sq;
    logic [SUM_W-1:0] r_sum;
    logic [M1_W-1:0]  r_m1;
    logic [M2_W-1:0]  r_m2;
    logic [ROW_W-1:0] r_first, r_last;
    logic             r_found, r_pend;
    logic [7:0]       r_prev, r_row0, r_row1, r_up_above, r_up_pix, r_lo_pix, r_lo_below;
    logic [CNT_W-1:0] r_trans;
    logic [N_W-1:0]   r_below;

    logic [ROW_W-1:0] n_first, n_last;
    logic             n_found, n_pend;
    logic [7:0]       n_row0, n_row1, n_up_above, n_up_pix, n_lo_pix, n_lo_below;
    logic [CNT_W-1:0] n_trans;
    logic [N_W-1:0]   n_below;
    logic [SUM_W-1:0] n_sum;
    logic [M1_W-1:0]  n_m1;
    logic [M2_W-1:0]  n_m2;

    logic             acc, last_px, fg;
    logic [N_W-1:0]   n_cnt;
    logic [8:0]       ug, lg;
    logic [N_W-1:0]   c_adj, span;

    // Column snapshot.
    logic [SUM_W-1:0] r_h_sum;
    logic [M1_W-1:0]  r_h_m1;
    logic [M2_W-1:0]  r_h_m2;
    logic [N_W-1:0]   r_h_n, r_h_c, r_h_span;
    logic             r_h_found;
    logic [ROW_W-1:0] r_h_u, r_h_l;
    logic [8:0]       r_h_ug, r_h_lg;
    logic [CNT_W-1:0] r_h_trans;
    logic [15:0]      r_q_w;
    logic [21:0]      r_q_g, r_q_m;
    logic [7:0]       r_q_f;
    logic [OUT_W-1:0] r_out;
    logic [DEN_W-1:0] nn;

    assign acc     = i_s_tvalid && i_cmd.in_ready;
    assign last_px = i_column_end || (r_row == ROW_W'(COLUMN_HEIGHT - 1));
    assign fg      = i_pixel <= r_thr;
    assign n_cnt   = N_W'(r_row) + 1'b1;

    always_comb begin
        n_sum = r_sum + SUM_W'(i_pixel);
        n_m1  = r_m1 + M1_W'(i_pixel * r_row);
        n_m2  = r_m2 + M2_W'(i_pixel * r_sq);
        n_trans = r_trans;
        if (r_row != '0 && ((r_prev > r_thr) != (i_pixel > r_thr)))
            n_trans = r_trans + 1'b1;
        n_lo_below = r_pend ? i_pixel : r_lo_below;
        n_pend     = 1'b0;
        n_row0     = (r_row == ROW_W'(0)) ? i_pixel : r_row0;
        n_row1     = (r_row == ROW_W'(1)) ? i_pixel : r_row1;
        n_found    = r_found;
        n_first    = r_first;
        n_up_pix   = r_up_pix;
        n_up_above = r_up_above;
        n_last     = r_last;
        n_lo_pix   = r_lo_pix;
        if (fg) begin
            if (!r_found) begin
                n_found    = 1'b1;
                n_first    = r_row;
                n_up_pix   = i_pixel;
                n_up_above = (r_row != '0) ? r_prev : 8'hFF;
            end
            n_last   = r_row;
            n_lo_pix = i_pixel;
            n_pend   = 1'b1;
        end else begin
            n_pend = r_pend && 1'b0;
        end
        n_below = (i_pixel < r_thr) ? r_below + 1'b1 : r_below;

        if (n_found) begin
            ug = {1'b0, n_up_above} - {1'b0, n_up_pix};
            lg = n_pend ? 9'h0FF - {1'b0, n_lo_pix}
                        : {1'b0, n_lo_below} - {1'b0, n_lo_pix};
        end else begin
            ug = (n_cnt > N_W'(1)) ? {1'b0, r_prev} - {1'b0, i_pixel}
                                   : 9'h0FF - {1'b0, i_pixel};
            lg = (n_cnt > N_W'(1)) ? {1'b0, n_row1} - {1'b0, n_row0}
                                   : 9'h0FF - {1'b0, n_row0};
        end
        c_adj = (n_below != '0) ? n_below - 1'b1 : n_below;
        span  = N_W'(n_last) - N_W'(n_first) + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= 8'd128;
            r_row   <= '0;
            r_sq    <= '0;
            r_sum   <= '0;
            r_m1    <= '0;
            r_m2    <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_found <= 1'b0;
            r_pend  <= 1'b0;
            r_prev  <= '0;
            r_row0  <= '0;
            r_row1  <= '0;
            r_up_above <= '0;
            r_up_pix   <= '0;
            r_lo_pix   <= '0;
            r_lo_below <= '0;
            r_trans <= '0;
            r_below <= '0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (acc) begin
                if (last_px) begin
                    r_row   <= '0;
                    r_sq    <= '0;
                    r_sum   <= '0;
                    r_m1    <= '0;
                    r_m2    <= '0;
                    r_first <= '0;
                    r_last  <= '0;
                    r_found <= 1'b0;
                    r_pend  <= 1'b0;
                    r_prev  <= '0;
                    r_row0  <= '0;
                    r_row1  <= '0;
                    r_up_above <= '0;
                    r_up_pix   <= '0;
                    r_lo_pix   <= '0;
                    r_lo_below <= '0;
                    r_trans <= '0;
                    r_below <= '0;
                end else begin
                    r_row   <= r_row + 1'b1;
                    r_sq    <= r_sq + SQ_W'({r_row, 1'b1});
                    r_sum   <= n_sum;
                    r_m1    <= n_m1;
                    r_m2    <= n_m2;
                    r_first <= n_first;
                    r_last  <= n_last;
                    r_found <= n_found;
                    r_pend  <= n_pend;
                    r_prev  <= i_pixel;
                    r_row0  <= n_row0;
                    r_row1  <= n_row1;
                    r_up_above <= n_up_above;
                    r_up_pix   <= n_up_pix;
                    r_lo_pix   <= n_lo_pix;
                    r_lo_below <= n_lo_below;
                    r_trans <= n_trans;
                    r_below <= n_below;
                end
            end
        end
    end

    // Snapshot and result registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (acc && last_px) begin
            r_h_sum   <= n_sum;
            r_h_m1    <= n_m1;
            r_h_m2    <= n_m2;
            r_h_n     <= n_cnt;
            r_h_found <= n_found;
            r_h_c     <= c_adj;
            r_h_span  <= span;
            r_h_u     <= n_found ? n_first : r_row;
            r_h_l     <= n_found ? n_last : '0;
            r_h_ug    <= ug;
            r_h_lg    <= lg;
            r_h_trans <= n_trans;
        end
        if (i_cmd.store_q) begin
            case (i_cmd.op)
                OP_WEIGHT:  r_q_w <= (i_div_quo > NUM_W'(16'hFFFF)) ? 16'hFFFF
                                                                    : i_div_quo[15:0];
                OP_GRAVITY: r_q_g <= (i_div_quo > NUM_W'(22'h3FFFFF)) ? 22'h3FFFFF
                                                                      : i_div_quo[21:0];
                OP_MOMENT:  r_q_m <= (i_div_quo > NUM_W'(22'h3FFFFF)) ? 22'h3FFFFF
                                                                      : i_div_quo[21:0];
                OP_FILL:    r_q_f <= (i_div_quo > NUM_W'(8'hFF)) ? 8'hFF : i_div_quo[7:0];
                default:    r_q_f <= r_q_f;
            endcase
        end
        if (i_cmd.load_out)
            r_out <= {r_q_f, r_h_trans, r_h_lg, r_h_ug, r_h_l, r_h_u, r_q_m, r_q_g, r_q_w};
    end

    assign nn = DEN_W'(r_h_n * r_h_n);

    // Each division rounds to nearest by adding half the divisor first.
    always_comb begin
        case (i_cmd.op)
            OP_WEIGHT: begin
                o_div_den = DEN_W'(r_h_n);
                o_div_num = NUM_W'({r_h_sum, 8'b0}) + NUM_W'(r_h_n >> 1);
            end
            OP_GRAVITY: begin
                o_div_den = DEN_W'(r_h_n);
                o_div_num = NUM_W'({r_h_m1, 8'b0}) + NUM_W'(r_h_n >> 1);
            end
            OP_MOMENT: begin
                o_div_den = nn;
                o_div_num = NUM_W'({r_h_m2, 8'b0}) + NUM_W'(nn >> 1);
            end
            OP_FILL: begin
                o_div_den = r_h_found ? DEN_W'(r_h_span) : DEN_W'(1);
                o_div_num = r_h_found ? NUM_W'({r_h_c, 8'b0}) + NUM_W'(r_h_span >> 1)
                                      : '0;
            end
            default: begin
                o_div_den = DEN_W'(1);
                o_div_num = '0;
            end
        endcase
    end

    assign o_div_start  = i_cmd.div_start;
    assign o_sts.col_done = acc && last_px;
    assign o_sts.div_done = i_div_done;
    assign o_result = r_out;
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the column profile feature extractor.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cpf_pkg::*;

    typedef struct packed {
        logic [7:0]  fill_ratio;
        logic [5:0]  transitions;
        logic [8:0]  lower_gradient;
        logic [8:0]  upper_gradient;
        logic [5:0]  lower_contour;
        logic [5:0]  upper_contour;
        logic [21:0] moment_two;
        logic [21:0] gravity;
        logic [15:0] weight;
    } t_features;

    // Predicts one feature set per column and checks the results in order.
    class feature_board;
        int unsigned thr;
        int unsigned row;
        longint unsigned psum, m1, m2;
        int unsigned first_fg, last_fg, prev_px, trans, below;
        bit found;
        int unsigned row0, row1, up_above, up_px, lo_px, lo_below;
        bit lo_wait;
        t_features pending[$];
        int errors;

        function void clear_column();
            row = 0; psum = 0; m1 = 0; m2 = 0; first_fg = 0; last_fg = 0;
            found = 0; prev_px = 0; trans = 0; below = 0;
            row0 = 0; row1 = 0; up_above = 0; up_px = 0; lo_px = 0; lo_below = 0;
            lo_wait = 0;
        endfunction

        function longint unsigned rdiv(longint unsigned num, longint unsigned den,
                                       longint unsigned lim);
            longint unsigned q;
            q = (num + den / 2) / den;
            return q > lim ? lim : q;
        endfunction

        function void note_pixel(logic [7:0] px, logic col_end);
            int unsigned p, i, old;
            longint unsigned n, c;
            int ug, lg;
            t_features f;
            p = px; i = row; old = prev_px;
            psum += p; m1 += p * i; m2 += longint'(p) * i * i;
            if (i > 0 && ((old > thr) != (p > thr))) trans++;
            if (lo_wait) begin
                lo_below = p;
                lo_wait = 0;
            end
            if (i == 0) row0 = p;
            if (i == 1) row1 = p;
            if (p <= thr) begin
                if (!found) begin
                    found = 1; first_fg = i; up_px = p;
                    up_above = (i > 0) ? old : 255;
                end
                last_fg = i; lo_px = p; lo_wait = 1;
            end
            if (p < thr) below++;
            prev_px = p;
            if (!col_end && i < COLUMN_HEIGHT - 1) begin
                row = i + 1;
                return;
            end
            n = i + 1;
            if (found) begin
                c = below;
                if (c > 0) c--;
                f.upper_contour = 6'(first_fg);
                f.lower_contour = 6'(last_fg);
                ug = int'(up_above) - int'(up_px);
                lg = lo_wait ? 255 - int'(lo_px) : int'(lo_below) - int'(lo_px);
                f.fill_ratio = 8'(rdiv(c * 256, last_fg - first_fg + 1, 255));
            end else begin
                f.upper_contour = 6'(n - 1);
                f.lower_contour = '0;
                ug = (n > 1) ? int'(old) - int'(p) : 255 - int'(p);
                lg = (n > 1) ? int'(row1) - int'(row0) : 255 - int'(row0);
                f.fill_ratio = '0;
            end
            f.upper_gradient = ug[8:0];
            f.lower_gradient = lg[8:0];
            f.weight = 16'(rdiv(psum * 256, n, 16'hFFFF));
            f.gravity = 22'(rdiv(m1 * 256, n, 22'h3FFFFF));
            f.moment_two = 22'(rdiv(m2 * 256, n * n, 22'h3FFFFF));
            f.transitions = 6'(trans > 63 ? 63 : trans);
            pending = {pending, f};
            clear_column();
        endfunction

        function void check_features(t_features got);
            t_features exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.weight != exp.weight)
                $display("%0t: weight exp %0d got %0d", $time, exp.weight, got.weight);
            if (got.gravity != exp.gravity)
                $display("%0t: gravity exp %0d got %0d", $time, exp.gravity, got.gravity);
            if (got.moment_two != exp.moment_two)
                $display("%0t: moment_two exp %0d got %0d", $time, exp.moment_two,
                         got.moment_two);
            if (got.upper_contour != exp.upper_contour)
                $display("%0t: upper_contour exp %0d got %0d", $time, exp.upper_contour,
                         got.upper_contour);
            if (got.lower_contour != exp.lower_contour)
                $display("%0t: lower_contour exp %0d got %0d", $time, exp.lower_contour,
                         got.lower_contour);
            if (got.upper_gradient != exp.upper_gradient)
                $display("%0t: upper_gradient exp %h got %h", $time, exp.upper_gradient,
                         got.upper_gradient);
            if (got.lower_gradient != exp.lower_gradient)
                $display("%0t: lower_gradient exp %h got %h", $time, exp.lower_gradient,
                         got.lower_gradient);
            if (got.transitions != exp.transitions)
                $display("%0t: transitions exp %0d got %0d", $time, exp.transitions,
                         got.transitions);
            if (got.fill_ratio != exp.fill_ratio)
                $display("%0t: fill_ratio exp %0d got %0d", $time, exp.fill_ratio,
                         got.fill_ratio);
            if (got != exp) errors++;
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [7:0] i_cfg_data = 0;
    logic s_axis_tvalid = 0, s_axis_tready, s_axis_tlast = 0;
    logic [7:0] s_axis_tdata = 0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;

    feature_board board = new();
    int send_idle = 0, recv_stall = 0;
    int quiet_cycles = 0;

    column_profile_features i_dut (.*);

    initial forever #5 i_clk = ~i_clk;

    // Receiver with random stalls; results are checked on each transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_features(t_features'(m_axis_tdata[$bits(t_features)-1:0]));
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: fails the run when no channel transfers past the limit on quiet_cycles.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("column_profile_features verification failed");
            $finish;
        end
    end

    // The valid line stays high after a transfer until the next idle cycle or drain.
    task automatic send_pixel(logic [7:0] px, logic last);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= px;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_pixel(px, last);
    endtask

    task automatic write_threshold(logic [7:0] t);
        i_cfg_valid <= 1;
        i_cfg_data <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.thr = t;
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Random column: a text-like profile with about one pixel in four replaced by noise.
    task automatic send_column(int height, bit forced_end);
        int top, bot, k;
        logic [7:0] px;
        top = $urandom_range(height - 1);
        bot = $urandom_range(height - 1, top);
        for (k = 0; k < height; k++) begin
            case ($urandom_range(3))
                0: px = 8'($urandom);
                default: px = (k >= top && k <= bot && $urandom_range(3) != 0)
                              ? 8'($urandom_range(90)) : 8'($urandom_range(255, 170));
            endcase
            send_pixel(px, forced_end ? (k == height - 1) : 1'b0);
        end
    endtask

    initial begin
        int k, n, phase;
        board.thr = 128;
        board.clear_column();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: one, two and three pixels; full height white, black, alternating.
        send_pixel(8'd0, 1);
        send_pixel(8'd255, 1);
        send_pixel(8'd128, 0); send_pixel(8'd129, 1);
        send_pixel(8'd255, 0); send_pixel(8'd127, 0); send_pixel(8'd0, 1);
        for (k = 0; k < 64; k++) send_pixel(8'd255, 0);
        for (k = 0; k < 64; k++) send_pixel(8'd0, k == 63);
        for (k = 0; k < 64; k++) send_pixel(k[0] ? 8'd255 : 8'd0, 0);
        drain();
        write_threshold(8'd0);
        send_column(10, 1); send_pixel(8'd0, 1);
        drain();
        write_threshold(8'd255);
        send_column(12, 1); send_column(64, 0);
        drain();
        // Random phases with different idling patterns and thresholds.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 64; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 64; end
                default: begin send_idle = 23; recv_stall = 23; end
            endcase
            write_threshold(phase == 7 ? 8'd255 : 8'($urandom));
            n = 0;
            while (n < 35) begin
                k = ($urandom_range(9) == 0) ? 64 : $urandom_range(12, 1);
                send_column(k, k != 64 || $urandom_range(1));
                n += k;
            end
            drain();
        end
        if (board.errors == 0)
            $display("column_profile_features verification clean");
        else
            $display("column_profile_features verification failed");
        $finish;
    end
endmodule
`default_nettype wire
